// File: hw/rtl/table_interpolate_1d_core_assert.svh
// Assertion macros for the table interpolation core.
// Each macro expands to a labeled concurrent assertion, or to nothing in synthesis.
`ifndef TABLE_INTERPOLATE_1D_CORE_ASSERT_SVH
`define TABLE_INTERPOLATE_1D_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising clock edge outside reset
`define TI1D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Overlapping implication, checked at every rising clock edge outside reset
`define TI1D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TI1D_ASSERT(lbl, clk, rstn, prop, msg)
`define TI1D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ti1d_pkg.sv
package ti1d_pkg;

  // Field widths
  localparam int unsigned ValW      = 16;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned FracW     = 17;
  localparam int unsigned FracShift = 16;
  localparam int unsigned DiffW     = ValW + 1;
  localparam int unsigned ProdW     = DiffW + FracW + 1;

  // Q1.16 constants
  localparam logic [FracW-1:0] FracOne  = FracW'(1 << FracShift);
  localparam logic [FracW-1:0] FracZero = '0;
  localparam int unsigned      FracHalf = 1 << (FracShift - 1);

  // Table geometry
  localparam int unsigned MaxBins         = 8;
  localparam int unsigned BinCountDefault = 8;
  localparam int unsigned WordsPerReg     = 4;

  // Divider: 32-bit dividend, 16-bit divisor, one quotient bit per stage
  localparam int unsigned DividendW = 2 * ValW;
  localparam int unsigned DivW      = ValW;
  localparam int unsigned DivSteps  = FracW;

  // Configuration port
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBpLow  = 2'd0,
    CfgBpHigh = 2'd1,
    CfgTvLow  = 2'd2,
    CfgTvHigh = 2'd3
  } cfg_reg_e;

  // Where the coordinate fell
  typedef enum logic [1:0] {
    ClsLow      = 2'd0,
    ClsInterior = 2'd1,
    ClsHigh     = 2'd2
  } seg_cls_e;

  // Item data that rides alongside the divider
  typedef struct packed {
    logic [IdxW-1:0]         idx;
    seg_cls_e                cls;
    logic signed [ValW-1:0]  v0;
    logic signed [DiffW-1:0] d;
    logic                    asc;
  } side_t;

endpackage

// File: hw/rtl/table_interpolate_1d_core.sv
// One-dimensional table lookup with linear interpolation, 8-entry tables.
// Pipeline: compare, select, 17 divider stages, multiply, round; the result strobe
// valid_o rises for each item taken once it has passed through all of them.
// Throughput: one item per cycle; busy_o stays low and the receiver cannot stall.
// Reset: async active low; clears all valid bits and the table registers to zero.
`include "table_interpolate_1d_core_assert.svh"

module table_interpolate_1d_core #(
  parameter int unsigned BinCount = ti1d_pkg::BinCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [ti1d_pkg::ValW-1:0]    x_value_i,
  input  logic                                cfg_we_i,
  input  logic [ti1d_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ti1d_pkg::CfgW-1:0]           cfg_wdata_i,
  output logic                                valid_o,
  output logic signed [ti1d_pkg::ValW-1:0]    result_value_o,
  output logic [ti1d_pkg::IdxW-1:0]           segment_index_o,
  output logic [ti1d_pkg::FracW-1:0]          segment_fraction_o,
  output logic                                bins_ascending_o
);
  import ti1d_pkg::*;

  localparam int unsigned UsedCount =
    (BinCount < 2) ? 2 : ((BinCount > MaxBins) ? MaxBins : BinCount);
  localparam int unsigned SegCount = UsedCount - 1;
  localparam logic [IdxW-1:0] LastSeg = IdxW'(UsedCount - 2);
  localparam int unsigned Latency = DivSteps + 4;

  logic accept;

  // Fully pipelined, never refuses an item
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers
  logic [CfgW-1:0] bp_lo_q, bp_hi_q, tv_lo_q, tv_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_lo_q <= '0;
      bp_hi_q <= '0;
      tv_lo_q <= '0;
      tv_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBpLow:  bp_lo_q <= cfg_wdata_i;
        CfgBpHigh: bp_hi_q <= cfg_wdata_i;
        CfgTvLow:  tv_lo_q <= cfg_wdata_i;
        CfgTvHigh: tv_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpacked breakpoint and value words
  logic signed [ValW-1:0] bp_w [MaxBins];
  logic signed [ValW-1:0] tv_w [MaxBins];

  for (genvar k = 0; k < MaxBins; k++) begin : g_words
    if (k < WordsPerReg) begin : g_lo
      assign bp_w[k] = bp_lo_q[ValW*k +: ValW];
      assign tv_w[k] = tv_lo_q[ValW*k +: ValW];
    end else begin : g_hi
      assign bp_w[k] = bp_hi_q[ValW*(k-WordsPerReg) +: ValW];
      assign tv_w[k] = tv_hi_q[ValW*(k-WordsPerReg) +: ValW];
    end
  end

  // Stage 1: parallel breakpoint compares
  logic [SegCount-1:0]    s1_gt_d;
  logic                   s1_asc_d;
  logic                   s1_vld_q;
  logic signed [ValW-1:0] s1_x_q;
  logic [SegCount-1:0]    s1_gt_q;
  logic                   s1_le0_q, s1_ge_q, s1_asc_q;

  always_comb begin
    s1_asc_d = 1'b1;
    for (int i = 0; i < SegCount; i++) begin
      s1_gt_d[i] = bp_w[i+1] > x_value_i;
      if (bp_w[i] >= bp_w[i+1]) begin
        s1_asc_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q   <= x_value_i;
    s1_gt_q  <= s1_gt_d;
    s1_le0_q <= x_value_i <= bp_w[0];
    s1_ge_q  <= x_value_i >= bp_w[UsedCount-1];
    s1_asc_q <= s1_asc_d;
  end

  // Stage 2: segment select, differences, divider operands
  logic [IdxW-1:0]         s2_idx;
  logic [IdxW-1:0]         s2_idx_nx;
  logic signed [DiffW-1:0] s2_num, s2_den;
  logic [DividendW-1:0]    s2_dividend_d;
  side_t                   s2_side_d;
  logic                    s2_vld_q;
  logic [DividendW-1:0]    s2_dividend_q;
  logic [DivW-1:0]         s2_divisor_q;
  side_t                   s2_side_q;

  always_comb begin
    // First segment whose upper breakpoint lies above x
    s2_idx = LastSeg;
    for (int i = int'(SegCount) - 1; i >= 0; i--) begin
      if (s1_gt_q[i]) begin
        s2_idx = IdxW'(i);
      end
    end
    s2_idx_nx = s2_idx + IdxW'(1);

    s2_num = {s1_x_q[ValW-1], s1_x_q} - {bp_w[s2_idx][ValW-1], bp_w[s2_idx]};
    s2_den = {bp_w[s2_idx_nx][ValW-1], bp_w[s2_idx_nx]}
           - {bp_w[s2_idx][ValW-1], bp_w[s2_idx]};

    // num * 65536 + den / 2; inside a segment num and den are non-negative
    s2_dividend_d = {s2_num[ValW-1:0], 1'b0, s2_den[ValW-1:1]};

    s2_side_d.asc = s1_asc_q;
    if (s1_le0_q) begin
      s2_side_d.cls = ClsLow;
      s2_side_d.idx = '0;
      s2_side_d.v0  = tv_w[0];
      s2_side_d.d   = '0;
    end else if (s1_ge_q) begin
      s2_side_d.cls = ClsHigh;
      s2_side_d.idx = LastSeg;
      s2_side_d.v0  = tv_w[UsedCount-1];
      s2_side_d.d   = '0;
    end else begin
      s2_side_d.cls = ClsInterior;
      s2_side_d.idx = s2_idx;
      s2_side_d.v0  = tv_w[s2_idx];
      s2_side_d.d   = {tv_w[s2_idx_nx][ValW-1], tv_w[s2_idx_nx]}
                    - {tv_w[s2_idx][ValW-1], tv_w[s2_idx]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_dividend_q <= s2_dividend_d;
    s2_divisor_q  <= s2_den[ValW-1:0];
    s2_side_q     <= s2_side_d;
  end

  // Fraction divider, one quotient bit per stage
  logic             dv_vld;
  logic [FracW-1:0] dv_quot;
  side_t            dv_side;

  ti1d_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_vld_q),
    .dividend_i  (s2_dividend_q),
    .divisor_i   (s2_divisor_q),
    .side_i      (s2_side_q),
    .out_valid_o (dv_vld),
    .quotient_o  (dv_quot),
    .side_o      (dv_side)
  );

  // Stage 3: fraction select and multiply
  logic [FracW-1:0]        s3_frac_d;
  logic signed [ProdW-1:0] s3_prod_d;
  logic                    s3_vld_q;
  logic signed [ProdW-1:0] s3_prod_q;
  logic signed [ValW-1:0]  s3_v0_q;
  logic [IdxW-1:0]         s3_idx_q;
  logic [FracW-1:0]        s3_frac_q;
  logic                    s3_asc_q;

  always_comb begin
    case (dv_side.cls)
      ClsLow:      s3_frac_d = FracZero;
      ClsHigh:     s3_frac_d = FracOne;
      ClsInterior: s3_frac_d = dv_quot;
      default:     s3_frac_d = FracZero;
    endcase
    s3_prod_d = ProdW'(dv_side.d) * ProdW'(signed'({1'b0, s3_frac_d}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_prod_q <= s3_prod_d;
    s3_v0_q   <= dv_side.v0;
    s3_idx_q  <= dv_side.idx;
    s3_frac_q <= s3_frac_d;
    s3_asc_q  <= dv_side.asc;
  end

  // Stage 4: round half up, add base value, output registers
  logic signed [ProdW-1:0] s4_rnd;
  logic signed [ProdW-1:0] s4_step;
  logic [ValW-1:0]         s4_result_d;
  logic                    out_vld_q;
  logic signed [ValW-1:0]  out_result_q;
  logic [IdxW-1:0]         out_idx_q;
  logic [FracW-1:0]        out_frac_q;
  logic                    out_asc_q;

  always_comb begin
    s4_rnd      = s3_prod_q + ProdW'(FracHalf);
    s4_step     = s4_rnd >>> FracShift;
    // True result lies between two table values, so 16-bit wrap is exact
    s4_result_d = s3_v0_q + s4_step[ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_result_q <= signed'(s4_result_d);
    out_idx_q    <= s3_idx_q;
    out_frac_q   <= s3_frac_q;
    out_asc_q    <= s3_asc_q;
  end

  assign valid_o            = out_vld_q;
  assign result_value_o     = out_result_q;
  assign segment_index_o    = out_idx_q;
  assign segment_fraction_o = out_frac_q;
  assign bins_ascending_o   = out_asc_q;

  // Checks
  `TI1D_ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, valid_o, $past(accept, Latency), "result without an item taken at fixed latency")
  `TI1D_ASSERT_IMPL(a_frac_range, clk_i, rst_ni, valid_o, segment_fraction_o <= FracOne, "fraction above one")
  `TI1D_ASSERT_IMPL(a_frac_zero_value, clk_i, rst_ni, valid_o && segment_fraction_o == FracZero, result_value_o == tv_w[segment_index_o], "zero fraction must give the lower table value")
  `TI1D_ASSERT_IMPL(a_frac_one_value, clk_i, rst_ni, valid_o && segment_fraction_o == FracOne, result_value_o == tv_w[IdxW'(segment_index_o + IdxW'(1))], "full fraction must give the upper table value")

endmodule

// File: hw/rtl/ti1d_divider.sv
module ti1d_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [ti1d_pkg::DividendW-1:0]      dividend_i,
  input  logic [ti1d_pkg::DivW-1:0]           divisor_i,
  input  ti1d_pkg::side_t                     side_i,
  output logic                                out_valid_o,
  output logic [ti1d_pkg::FracW-1:0]          quotient_o,
  output ti1d_pkg::side_t                     side_o
);
  import ti1d_pkg::*;

  // Per-stage registers; quotient bits shift in as dividend bits shift out
  logic                vld_q  [DivSteps];
  logic [DivW-1:0]     rem_q  [DivSteps];
  logic [FracW-1:0]    dq_q   [DivSteps];
  logic [DivW-1:0]     den_q  [DivSteps];
  side_t               side_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic             vld_in;
    logic [DivW-1:0]  rem_in;
    logic [FracW-1:0] dq_in;
    logic [DivW-1:0]  den_in;
    side_t            side_in;
    logic [DivW:0]    trial;

    if (k == 0) begin : g_first
      // The top dividend bits are already below the divisor
      assign vld_in  = in_valid_i;
      assign rem_in  = {1'b0, dividend_i[DividendW-1:FracW]};
      assign dq_in   = dividend_i[FracW-1:0];
      assign den_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dq_in   = dq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, dq_in[FracW-1]};

    // Valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    // Restoring step: subtract when the trial remainder allows it
    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, den_in}) begin
        rem_q[k] <= DivW'(trial - {1'b0, den_in});
        dq_q[k]  <= {dq_in[FracW-2:0], 1'b1};
      end else begin
        rem_q[k] <= trial[DivW-1:0];
        dq_q[k]  <= {dq_in[FracW-2:0], 1'b0};
      end
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign out_valid_o = vld_q[DivSteps-1];
  assign quotient_o  = dq_q[DivSteps-1];
  assign side_o      = side_q[DivSteps-1];

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ti1d_pkg::*;

  localparam int unsigned Bins          = BinCountDefault;
  localparam int unsigned Phases        = 8;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned TailCycles    = 40;   // well past the pipeline depth
  localparam int unsigned CycleLimit    = 200000;

  typedef logic signed [ValW-1:0] word_t;
  typedef word_t bank_t [MaxBins];

  // One lookup answer, as the result ports carry it
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        seg;
    logic [FracW-1:0]       frac;
    logic                   asc;
  } lookup_t;

  // Table contents used by the directed part
  typedef enum logic [1:0] {
    TblZero      = 2'd0,
    TblAscending = 2'd1,
    TblMixed     = 2'd2
  } tbl_set_e;

  typedef enum int {
    ShapeSorted, ShapeClustered, ShapeUnsorted, ShapeFlat, ShapeExtremes
  } bp_shape_e;

  typedef enum int {
    ValRandom, ValRails, ValSmall
  } val_shape_e;

  // Directed row: coordinate, and a typed answer where one is obvious
  typedef struct packed {
    tbl_set_e               tbl;
    logic signed [ValW-1:0] x;
    logic                   typed;
    lookup_t                want;
  } row_t;

  localparam bank_t AscBp  = '{16'sh8000, -16'sd20000, -16'sd1000, 16'sd0,
                               16'sd100, 16'sd5000, 16'sd20000, 16'sd32767};
  localparam bank_t AscVal = '{16'sh8000, 16'sd32767, -16'sd100, 16'sd50,
                               16'sd50, 16'sd1000, 16'sh8000, 16'sd32767};
  // Repeated and falling breakpoints
  localparam bank_t MixBp  = '{-16'sd100, -16'sd100, 16'sd50, 16'sd20,
                               16'sd300, 16'sd300, 16'sd1000, 16'sd2000};
  localparam bank_t MixVal = '{16'sd7, -16'sd7, 16'sd32767, 16'sh8000,
                               16'sd0, 16'sd1, 16'sd2, 16'sd3};

  localparam lookup_t NoWant = '0;

  localparam row_t Directed [24] = '{
    // tables cleared by reset: everything sits on one point
    '{TblZero, 16'sd0,      1'b1, '{16'sd0, 3'd0, FracZero, 1'b0}},
    '{TblZero, 16'sh8000,   1'b1, '{16'sd0, 3'd0, FracZero, 1'b0}},
    '{TblZero, 16'sd1,      1'b1, '{16'sd0, 3'd6, FracOne, 1'b0}},
    '{TblZero, 16'sd32767,  1'b1, '{16'sd0, 3'd6, FracOne, 1'b0}},
    // ascending tables spanning the full range
    '{TblAscending, 16'sh8000,   1'b1, '{16'sh8000, 3'd0, FracZero, 1'b1}},
    '{TblAscending, -16'sd32767, 1'b0, NoWant},
    '{TblAscending, -16'sd20000, 1'b1, '{16'sd32767, 3'd1, FracZero, 1'b1}},
    '{TblAscending, -16'sd1001,  1'b0, NoWant},
    '{TblAscending, -16'sd1,     1'b0, NoWant},
    '{TblAscending, 16'sd0,      1'b0, NoWant},
    '{TblAscending, 16'sd1,      1'b0, NoWant},
    '{TblAscending, 16'sd50,     1'b0, NoWant},
    '{TblAscending, 16'sd19999,  1'b0, NoWant},
    '{TblAscending, 16'sd32766,  1'b0, NoWant},
    '{TblAscending, 16'sd32767,  1'b1, '{16'sd32767, 3'd6, FracOne, 1'b1}},
    // non-ascending tables: search takes the first breakpoint above x
    '{TblMixed, 16'sh8000,  1'b1, '{16'sd7, 3'd0, FracZero, 1'b0}},
    '{TblMixed, -16'sd99,   1'b0, NoWant},
    '{TblMixed, 16'sd30,    1'b0, NoWant},
    '{TblMixed, 16'sd49,    1'b0, NoWant},
    '{TblMixed, 16'sd300,   1'b0, NoWant},
    '{TblMixed, 16'sd999,   1'b0, NoWant},
    '{TblMixed, 16'sd1999,  1'b0, NoWant},
    '{TblMixed, 16'sd2000,  1'b1, '{16'sd3, 3'd6, FracOne, 1'b0}},
    '{TblMixed, 16'sd32767, 1'b1, '{16'sd3, 3'd6, FracOne, 1'b0}}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic signed [ValW-1:0] x_value_i;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgW-1:0]        cfg_wdata_i;
  logic                   valid_o;
  logic signed [ValW-1:0] result_value_o;
  logic [IdxW-1:0]        segment_index_o;
  logic [FracW-1:0]       segment_fraction_o;
  logic                   bins_ascending_o;

  // Shadow of the table registers and the answers still in flight
  logic [CfgW-1:0] tbl_regs [4];
  lookup_t         pending_lookups [$];
  logic            pending_typed;
  lookup_t         pending_want;
  lookup_t         oldest;
  int              mismatches;
  int              cycles;

  table_interpolate_1d_core #(
    .BinCount(Bins)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .x_value_i         (x_value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .valid_o           (valid_o),
    .result_value_o    (result_value_o),
    .segment_index_o   (segment_index_o),
    .segment_fraction_o(segment_fraction_o),
    .bins_ascending_o  (bins_ascending_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand16();
    logic [ValW-1:0] bits;
    bits = ValW'($urandom);
    return int'($signed(bits));
  endfunction

  function automatic int table_word(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi, int k);
    logic [CfgW-1:0] r;
    r = (k < WordsPerReg) ? lo : hi;
    return int'($signed(r[ValW*(k % WordsPerReg) +: ValW]));
  endfunction

  // Segment search, Q1.16 position and rounded interpolation
  function automatic lookup_t interp_lookup(logic signed [ValW-1:0] x);
    int      b [MaxBins];
    int      v [MaxBins];
    int      xi;
    int      seg;
    bit      found;
    logic    asc;
    longint  one;
    longint  num;
    longint  den;
    longint  frac;
    longint  d;
    longint  acc;
    lookup_t r;
    one = longint'(1) << FracShift;
    xi  = int'(x);
    for (int k = 0; k < Bins; k++) begin
      b[k] = table_word(tbl_regs[CfgBpLow], tbl_regs[CfgBpHigh], k);
      v[k] = table_word(tbl_regs[CfgTvLow], tbl_regs[CfgTvHigh], k);
    end
    asc = 1'b1;
    for (int k = 0; k < Bins - 1; k++) begin
      if (b[k] >= b[k+1]) asc = 1'b0;
    end
    if (xi <= b[0]) begin
      seg  = 0;
      frac = 0;
      acc  = v[0];
    end else if (xi >= b[Bins-1]) begin
      seg  = Bins - 2;
      frac = one;
      acc  = v[Bins-1];
    end else begin
      seg   = Bins - 2;
      found = 1'b0;
      for (int k = 0; k < Bins - 1; k++) begin
        if (!found && b[k+1] > xi) begin
          seg   = k;
          found = 1'b1;
        end
      end
      num = longint'(xi) - b[seg];
      den = longint'(b[seg+1]) - b[seg];
      if (den <= 0 || num <= 0) begin
        frac = 0;
      end else begin
        frac = (num * one + den / 2) / den;
        if (frac > one) frac = one;
      end
      // floor of the scaled step, half rounds up
      d   = longint'(v[seg+1]) - v[seg];
      acc = longint'(v[seg]) + ((d * frac + longint'(FracHalf)) >>> FracShift);
    end
    r.value = acc[ValW-1:0];
    r.seg   = seg[IdxW-1:0];
    r.frac  = frac[FracW-1:0];
    r.asc   = asc;
    return r;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result check first, then record the item taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d", $time,
                   result_value_o);
          mismatches++;
        end else begin
          oldest = pending_lookups.pop_front();
          check_field("result_value", int'(oldest.value), int'(result_value_o));
          check_field("segment_index", int'(oldest.seg), int'(segment_index_o));
          check_field("segment_fraction", int'(oldest.frac), int'(segment_fraction_o));
          check_field("bins_ascending", int'(oldest.asc), int'(bins_ascending_o));
        end
      end
      if (start_i && !busy_o) begin
        pending_lookups.push_back(pending_typed ? pending_want : interp_lookup(x_value_i));
      end
    end
  end

  // Run time guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(logic signed [ValW-1:0] x, logic typed, lookup_t want);
    @(negedge clk_i);
    start_i       <= 1'b1;
    x_value_i     <= x;
    pending_typed  = typed;
    pending_want   = want;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding item come back
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tbl_regs[idx] = data;
  endtask

  task automatic load_tables(bank_t bps, bank_t vals);
    write_reg(CfgBpLow,  {bps[3], bps[2], bps[1], bps[0]});
    write_reg(CfgBpHigh, {bps[7], bps[6], bps[5], bps[4]});
    write_reg(CfgTvLow,  {vals[3], vals[2], vals[1], vals[0]});
    write_reg(CfgTvHigh, {vals[7], vals[6], vals[5], vals[4]});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic make_breakpoints(bp_shape_e shape, output bank_t b);
    int q [$];
    int base;
    int step;
    int step_max;
    case (shape)
      ShapeSorted: begin
        for (int k = 0; k < MaxBins; k++) q.push_back(rand16());
        q.sort();
        for (int k = 0; k < MaxBins; k++) b[k] = word_t'(q[k]);
      end
      ShapeClustered: begin
        base     = rand16();
        step_max = $urandom_range(0, 1) ? 4 : 300;
        for (int k = 0; k < MaxBins; k++) begin
          b[k] = word_t'(clamp16(base));
          step = $urandom_range(0, step_max);
          base = base + step;
        end
      end
      ShapeUnsorted: begin
        for (int k = 0; k < MaxBins; k++) b[k] = word_t'(rand16());
      end
      ShapeFlat: begin
        base = rand16();
        for (int k = 0; k < MaxBins; k++) b[k] = word_t'(base);
      end
      default: begin
        b = '{16'sh8000, -16'sd32767, -16'sd16384, -16'sd1,
              16'sd0, 16'sd16384, 16'sd32766, 16'sd32767};
      end
    endcase
  endtask

  task automatic make_values(val_shape_e shape, output bank_t v);
    bit flip;
    flip = $urandom_range(0, 1);
    for (int k = 0; k < MaxBins; k++) begin
      case (shape)
        ValRails: v[k] = ((k % 2 == 1) ^ flip) ? 16'sd32767 : 16'sh8000;
        ValSmall: v[k] = word_t'(int'($urandom_range(0, 200)) - 100);
        default:  v[k] = word_t'(rand16());
      endcase
    end
  endtask

  // Coordinates cluster around the breakpoints, with some spread and rails
  function automatic logic signed [ValW-1:0] pick_x(bank_t b);
    int r;
    int k;
    int off;
    r   = $urandom_range(0, 99);
    k   = $urandom_range(0, Bins - 1);
    off = $urandom_range(0, 8);
    if (r < 55) return word_t'(clamp16(int'(b[k]) + off - 4));
    if (r < 65) return b[k];
    if (r < 75) return $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
    return word_t'(rand16());
  endfunction

  initial begin
    bank_t      bps;
    bank_t      vals;
    bp_shape_e  shape;
    val_shape_e vshape;
    tbl_set_e   cur;
    bit         idle_on;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    x_value_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgBpLow;
    cfg_wdata_i   = '0;
    pending_typed = 1'b0;
    pending_want  = '0;
    mismatches    = 0;
    cycles        = 0;
    for (int r = 0; r < 4; r++) tbl_regs[r] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, tables switched only once the pipeline is empty
    cur = TblZero;
    for (int i = 0; i < $size(Directed); i++) begin
      if (Directed[i].tbl != cur) begin
        drain();
        cur = Directed[i].tbl;
        case (cur)
          TblAscending: load_tables(AscBp, AscVal);
          default:      load_tables(MixBp, MixVal);
        endcase
      end
      send_item(Directed[i].x, Directed[i].typed, Directed[i].want);
    end

    // Random phases, each with fresh tables; the last ones run without gaps
    for (int p = 0; p < Phases; p++) begin
      if (p == 0) begin
        shape  = ShapeExtremes;
        vshape = ValRails;
      end else if (p == 1) begin
        shape  = ShapeSorted;
        vshape = ValRandom;
      end else begin
        shape  = bp_shape_e'($urandom_range(0, 4));
        vshape = val_shape_e'($urandom_range(0, 2));
      end
      make_breakpoints(shape, bps);
      make_values(vshape, vals);
      drain();
      load_tables(bps, vals);
      idle_on = (p < Phases - 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (idle_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 8));
        send_item(pick_x(bps), 1'b0, NoWant);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
